@@ sv/mlps_pkg.sv @@
// Shared constants, controller states and control/status bundles of the scheduler.
package mlps_pkg;

	localparam int MAX_PROCS  = 64;
	localparam int MAX_LEVELS = 16;

	localparam int PID_W  = $clog2(MAX_PROCS);
	localparam int LVL_W  = $clog2(MAX_LEVELS);
	localparam int QIDX_W = LVL_W + 1;
	localparam int CFG_W  = 5;
	localparam int PRIO_W = 5;

	localparam logic [CFG_W-1:0] LEVELS_RESET = CFG_W'(4);

	typedef enum logic [0:0] {
		MODE_ADD = 1'b0,
		MODE_GET = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_POP_FIND,
		ST_POP_RD,
		ST_POP_WR,
		ST_PEEK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic add_rd;
		logic add_wr;
		logic swap;
		logic pop_rd;
		logic pop_link;
		logic pop_wr;
		logic peek_rd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic act_empty;
		logic swapped;
		logic out_free;
	} status_t;

endpackage

@@ sv/mlps_ctrl.sv @@
// Controller state machine that sequences add, pop and peek accesses.
module mlps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_mode,
	input  mlps_pkg::status_t sts,
	output mlps_pkg::cmd_t   cmd,
	output logic             in_stall
);

	mlps_pkg::state_t state_q;
	mlps_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlps_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			mlps_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (in_mode == mlps_pkg::MODE_GET) begin
						state_nx = mlps_pkg::ST_POP_FIND;
					end else begin
						state_nx = mlps_pkg::ST_ADD_RD;
					end
				end
			end
			mlps_pkg::ST_ADD_RD: begin
				cmd.add_rd = 1'b1;
				state_nx   = mlps_pkg::ST_ADD_WR;
			end
			mlps_pkg::ST_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_nx   = mlps_pkg::ST_PEEK;
			end
			mlps_pkg::ST_POP_FIND: begin
				// An empty active bank swaps once; a second miss means both banks are empty.
				if (sts.act_empty && !sts.swapped) begin
					cmd.swap = 1'b1;
				end else if (sts.act_empty) begin
					state_nx = mlps_pkg::ST_PEEK;
				end else begin
					cmd.pop_rd = 1'b1;
					state_nx   = mlps_pkg::ST_POP_RD;
				end
			end
			mlps_pkg::ST_POP_RD: begin
				cmd.pop_link = 1'b1;
				state_nx     = mlps_pkg::ST_POP_WR;
			end
			mlps_pkg::ST_POP_WR: begin
				cmd.pop_wr = 1'b1;
				state_nx   = mlps_pkg::ST_PEEK;
			end
			mlps_pkg::ST_PEEK: begin
				cmd.peek_rd = 1'b1;
				state_nx    = mlps_pkg::ST_FINISH;
			end
			mlps_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = mlps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = mlps_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/mlps_dpath.sv @@
// Datapath: queue memories, nonempty bits, bank select and the result register.
module mlps_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mlps_pkg::cmd_t                cmd,
	output mlps_pkg::status_t             sts,
	input  logic                          mode,
	input  logic [mlps_pkg::PID_W-1:0]    process_id,
	input  logic [mlps_pkg::PRIO_W-1:0]   base_prio,
	input  logic [mlps_pkg::PRIO_W-1:0]   cur_prio,
	input  logic                          cfg_valid,
	input  logic [mlps_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          res_stall,
	output logic                          res_valid,
	output logic                          out_valid,
	output logic [mlps_pkg::PID_W-1:0]    out_process_id,
	output logic [mlps_pkg::LVL_W-1:0]    out_priority,
	output logic                          to_expired,
	output logic                          banks_swapped,
	output logic                          peek_valid,
	output logic [mlps_pkg::PID_W-1:0]    peek_process_id
);

	localparam int NQ = 2 * mlps_pkg::MAX_LEVELS;

	logic [mlps_pkg::PID_W-1:0] link_mem [mlps_pkg::MAX_PROCS];
	logic [mlps_pkg::PID_W-1:0] head_mem [NQ];
	logic [mlps_pkg::PID_W-1:0] tail_mem [NQ];

	logic [mlps_pkg::MAX_LEVELS-1:0] nonempty_q [2];
	logic                            active_q;
	logic [mlps_pkg::CFG_W-1:0]      levels_q;

	logic                        is_get_q;
	logic [mlps_pkg::PID_W-1:0]  pid_q;
	logic [mlps_pkg::LVL_W-1:0]  add_lvl_q;
	logic                        add_exp_q;
	logic [mlps_pkg::LVL_W-1:0]  pop_lvl_q;
	logic [mlps_pkg::PID_W-1:0]  pop_pid_q;
	logic                        got_q;
	logic                        swapped_q;
	logic                        peek_valid_q;

	logic [mlps_pkg::PID_W-1:0]  head_rd_q;
	logic [mlps_pkg::PID_W-1:0]  tail_rd_q;
	logic [mlps_pkg::PID_W-1:0]  link_rd_q;

	logic                        res_valid_q;

	// Clamped priorities of the incoming beat.
	logic [mlps_pkg::CFG_W-1:0]  eff_levels;
	logic [mlps_pkg::PRIO_W-1:0] sp_c;
	logic [mlps_pkg::PRIO_W-1:0] dp_c;
	logic                        new_exp;
	logic [mlps_pkg::LVL_W-1:0]  new_lvl;

	logic                        add_bank;
	logic                        add_ne;
	logic [mlps_pkg::QIDX_W-1:0] q_add;
	logic [mlps_pkg::QIDX_W-1:0] q_pop;
	logic [mlps_pkg::QIDX_W-1:0] q_top;
	logic                        act_found;
	logic [mlps_pkg::LVL_W-1:0]  act_lvl;
	logic                        pop_last;

	logic                        head_we;
	logic [mlps_pkg::QIDX_W-1:0] head_wa;
	logic [mlps_pkg::PID_W-1:0]  head_wd;
	logic [mlps_pkg::QIDX_W-1:0] tail_ra;

	always_comb begin
		if (levels_q == '0) begin
			eff_levels = mlps_pkg::CFG_W'(1);
		end else if (levels_q > mlps_pkg::CFG_W'(mlps_pkg::MAX_LEVELS)) begin
			eff_levels = mlps_pkg::CFG_W'(mlps_pkg::MAX_LEVELS);
		end else begin
			eff_levels = levels_q;
		end

		if (base_prio == '0) begin
			sp_c = mlps_pkg::PRIO_W'(1);
		end else if (base_prio > mlps_pkg::PRIO_W'(eff_levels)) begin
			sp_c = mlps_pkg::PRIO_W'(eff_levels);
		end else begin
			sp_c = base_prio;
		end

		if (cur_prio > mlps_pkg::PRIO_W'(eff_levels)) begin
			dp_c = mlps_pkg::PRIO_W'(eff_levels);
		end else begin
			dp_c = cur_prio;
		end

		new_exp = (dp_c == '0);
		if (new_exp) begin
			new_lvl = mlps_pkg::LVL_W'(sp_c - mlps_pkg::PRIO_W'(1));
		end else begin
			new_lvl = mlps_pkg::LVL_W'(dp_c - mlps_pkg::PRIO_W'(1));
		end
	end

	// Highest set bit of the active bank's nonempty mask.
	always_comb begin
		act_found = 1'b0;
		act_lvl   = '0;
		for (int i = 0; i < mlps_pkg::MAX_LEVELS; i++) begin
			if (nonempty_q[active_q][i]) begin
				act_found = 1'b1;
				act_lvl   = mlps_pkg::LVL_W'(i);
			end
		end
	end

	assign add_bank = active_q ^ add_exp_q;
	assign add_ne   = nonempty_q[add_bank][add_lvl_q];
	assign q_add    = {add_bank, add_lvl_q};
	assign q_pop    = {active_q, pop_lvl_q};
	assign q_top    = {active_q, act_lvl};
	assign pop_last = (head_rd_q == tail_rd_q);

	assign head_we = (cmd.add_wr && !add_ne) || (cmd.pop_wr && !pop_last);
	assign head_wa = cmd.add_wr ? q_add : q_pop;
	assign head_wd = cmd.add_wr ? pid_q : link_rd_q;
	assign tail_ra = cmd.add_rd ? q_add : q_top;

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		if (cmd.pop_rd || cmd.peek_rd) begin
			head_rd_q <= head_mem[q_top];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_wr) begin
			tail_mem[q_add] <= pid_q;
		end
		if (cmd.add_rd || cmd.pop_rd) begin
			tail_rd_q <= tail_mem[tail_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_wr && add_ne) begin
			link_mem[tail_rd_q] <= pid_q;
		end
		if (cmd.pop_link) begin
			link_rd_q <= link_mem[head_rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q[0] <= '0;
			nonempty_q[1] <= '0;
			active_q      <= 1'b0;
			levels_q      <= mlps_pkg::LEVELS_RESET;
			swapped_q     <= 1'b0;
			got_q         <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				levels_q <= cfg_data;
			end
			if (cmd.add_wr) begin
				nonempty_q[add_bank][add_lvl_q] <= 1'b1;
			end
			if (cmd.pop_wr && pop_last) begin
				nonempty_q[active_q][pop_lvl_q] <= 1'b0;
			end
			if (cmd.capture) begin
				swapped_q <= 1'b0;
				got_q     <= 1'b0;
			end
			if (cmd.swap) begin
				active_q  <= ~active_q;
				swapped_q <= 1'b1;
			end
			if (cmd.pop_wr) begin
				got_q <= 1'b1;
			end
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			is_get_q  <= (mlps_pkg::mode_t'(mode) == mlps_pkg::MODE_GET);
			pid_q     <= process_id;
			add_lvl_q <= new_lvl;
			add_exp_q <= new_exp;
		end
		if (cmd.pop_rd) begin
			pop_lvl_q <= act_lvl;
		end
		if (cmd.pop_wr) begin
			pop_pid_q <= head_rd_q;
		end
		if (cmd.peek_rd) begin
			peek_valid_q <= act_found;
		end
		if (cmd.load_out) begin
			out_valid       <= !is_get_q || got_q;
			out_process_id  <= !is_get_q ? pid_q : (got_q ? pop_pid_q : '0);
			out_priority    <= !is_get_q ? add_lvl_q : (got_q ? pop_lvl_q : '0);
			to_expired      <= !is_get_q && add_exp_q;
			banks_swapped   <= is_get_q && swapped_q;
			peek_valid      <= peek_valid_q;
			peek_process_id <= peek_valid_q ? head_rd_q : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign sts       = {!act_found, swapped_q, (!res_valid_q || !res_stall)};

endmodule

@@ sv/multilevel_priority_scheduler.sv @@
// Top level of the multilevel priority scheduler: controller, datapath and checks.
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   mode, process_id, base_prio, cur_prio
// result    out        res_valid / res_stall out_valid .. peek_process_id
// config    in         cfg_valid / cfg_ready cfg_data (levels_in_use)
//
// An add runs ST_ADD_RD, ST_ADD_WR, ST_PEEK; a get runs ST_POP_FIND, swapping banks once if
// the active bank is empty, then ST_POP_RD, ST_POP_WR, ST_PEEK, or ST_PEEK alone if both are
// empty. ST_FINISH loads the result. Head, tail and link memory reads are all registered.
// One beat is in flight at a time and the next beat is taken in the cycle after the load; a
// finished result waits in the output register while the next beat is accepted, and the
// controller holds before loading it until that register frees.
// Reset clears the nonempty bits, the active bank and the state; levels_in_use resets to 4.
module multilevel_priority_scheduler (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [mlps_pkg::PID_W-1:0]   process_id,
	input  logic [mlps_pkg::PRIO_W-1:0]  base_prio,
	input  logic [mlps_pkg::PRIO_W-1:0]  cur_prio,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic                         out_valid,
	output logic [mlps_pkg::PID_W-1:0]   out_process_id,
	output logic [mlps_pkg::LVL_W-1:0]   out_priority,
	output logic                         to_expired,
	output logic                         banks_swapped,
	output logic                         peek_valid,
	output logic [mlps_pkg::PID_W-1:0]   peek_process_id,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mlps_pkg::CFG_W-1:0]   cfg_data
);

	mlps_pkg::cmd_t    cmd;
	mlps_pkg::status_t sts;

	assign cfg_ready = 1'b1;

	mlps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (mode),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	mlps_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.mode             (mode),
		.process_id       (process_id),
		.base_prio        (base_prio),
		.cur_prio         (cur_prio),
		.cfg_valid        (cfg_valid && cfg_ready),
		.cfg_data         (cfg_data),
		.res_stall        (res_stall),
		.res_valid        (res_valid),
		.out_valid        (out_valid),
		.out_process_id   (out_process_id),
		.out_priority     (out_priority),
		.to_expired       (to_expired),
		.banks_swapped    (banks_swapped),
		.peek_valid       (peek_valid),
		.peek_process_id  (peek_process_id)
	);

`ifndef ASSERT_OFF
	// A beat that was just taken keeps the input side stalled until it completes.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a beat is in progress");

	// The result register is loaded only when it is free.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(res_valid && res_stall))
		else $error("result register overwritten while stalled");

	// An add never swaps and a get never expires a process.
	a_expire_xor_swap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(to_expired && banks_swapped))
		else $error("result reports both expiry and bank swap");

	// A result with nothing in the active bank shows a zero peek.
	a_peek_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !peek_valid) |-> (peek_process_id == '0))
		else $error("peek id set with empty active bank");
`endif

endmodule
